// ===== sv/ptts_pkg.sv =====
// Package for the periodic task tick scheduler.
// Holds the field widths, command codes and the slot entry type.
// Used by the channel interfaces, the slot table and the top level.
`default_nettype none

package ptts_pkg;

  // Field widths of the command and result transactions.
  localparam int unsigned ModeW   = 3;
  localparam int unsigned SlotW   = 3;
  localparam int unsigned TimeW   = 16;
  localparam int unsigned HandleW = 8;

  // Default number of task slots and the dispatch limit per tick.
  localparam int unsigned TasksDefault = 8;
  localparam int unsigned MaxResults   = 8;

  // Command codes carried in the mode field.
  typedef enum logic [ModeW-1:0] {
    MODE_TICK    = 3'd0,
    MODE_CREATE  = 3'd1,
    MODE_SUSPEND = 3'd2,
    MODE_RESUME  = 3'd3,
    MODE_DELETE  = 3'd4
  } mode_e;

  // Status codes of a result.
  localparam logic STATUS_OK        = 1'b0;
  localparam logic STATUS_NO_HANDLE = 1'b1;

  // One task slot as stored in the slot table.
  typedef struct packed {
    logic [HandleW-1:0] handle;
    logic [TimeW-1:0]   period;
    logic [TimeW-1:0]   countdown;
    logic               suspended;
  } slot_entry_t;

endpackage : ptts_pkg

`default_nettype wire

// ===== sv/ptts_if.sv =====
// Channel interfaces of the periodic task tick scheduler.
// Command channel and result channel, each a valid/ready handshake.
// Depends on ptts_pkg for the field widths.
`default_nettype none

interface ptts_cmd_if import ptts_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [ModeW-1:0]   mode;
  logic [SlotW-1:0]   slot;
  logic [TimeW-1:0]   period;
  logic [TimeW-1:0]   first_delay;
  logic [HandleW-1:0] task_handle;

  modport source (
    output valid, mode, slot, period, first_delay, task_handle,
    input  ready
  );

  modport sink (
    input  valid, mode, slot, period, first_delay, task_handle,
    output ready
  );
endinterface : ptts_cmd_if

interface ptts_res_if import ptts_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               status;
  logic               dispatch;
  logic [SlotW-1:0]   run_slot;
  logic [HandleW-1:0] run_handle;
  logic               last;

  modport source (
    output valid, status, dispatch, run_slot, run_handle, last,
    input  ready
  );

  modport sink (
    input  valid, status, dispatch, run_slot, run_handle, last,
    output ready
  );
endinterface : ptts_res_if

`default_nettype wire

// ===== sv/periodic_task_tick_scheduler.sv =====
// Top level of the periodic task tick scheduler.
// Command decoding, the tick walk sequencer and the result register.
// Depends on ptts_pkg, ptts_if and ptts_slot_table.
//
//   Channel  Direction  Port   Transaction
//   command  in         cmd_i  one tick, create, suspend, resume or delete
//   result   out        res_o  status or one dispatch; last marks the end
//
// A non-tick command reads its slot, then updates it and registers the result.
// A tick reads one slot per cycle through the single table read port, except
// while a dispatch waits because the result register is full.
// The block takes a new command only when the previous one has finished.
// Reset clears the slot valid bits, so every slot starts empty and resumed.
// A stalled result channel holds the walk; no result is dropped.
`default_nettype none

module periodic_task_tick_scheduler import ptts_pkg::*; #(
  parameter int unsigned TASKS = TasksDefault
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  ptts_cmd_if.sink  cmd_i,
  ptts_res_if.source res_o
);

  localparam int unsigned IdxW = (TASKS > 1) ? $clog2(TASKS) : 1;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(TASKS - 1);
  localparam int unsigned CntW = $clog2(MaxResults + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMD,
    S_WALK,
    S_FLUSH
  } state_e;

  state_e state_q;

  // Latched command.
  logic [ModeW-1:0]   mode_q;
  logic [SlotW-1:0]   slot_q;
  logic [TimeW-1:0]   period_q;
  logic [TimeW-1:0]   delay_q;
  logic [HandleW-1:0] handle_q;

  // Tick walk state.
  logic [IdxW-1:0]    idx_q;
  logic [CntW-1:0]    disp_cnt_q;
  logic               pend_valid_q;
  logic [SlotW-1:0]   pend_slot_q;
  logic [HandleW-1:0] pend_handle_q;

  // Result register.
  logic               res_valid_q;
  logic               res_status_q;
  logic               res_dispatch_q;
  logic [SlotW-1:0]   res_slot_q;
  logic [HandleW-1:0] res_handle_q;
  logic               res_last_q;

  // Slot table ports.
  logic            rd_en;
  logic [IdxW-1:0] rd_addr;
  slot_entry_t     rd_data;
  logic            wr_en;
  logic [IdxW-1:0] wr_addr;
  slot_entry_t     wr_data;

  logic cmd_accept;
  logic res_free;
  logic cmd_slot_ok;
  logic in_slot_ok;

  assign cmd_i.ready = (state_q == S_IDLE);
  assign cmd_accept  = cmd_i.valid && cmd_i.ready;
  assign res_free    = !res_valid_q || res_o.ready;
  assign in_slot_ok  = (32'(cmd_i.slot) < TASKS);
  assign cmd_slot_ok = (32'(slot_q) < TASKS);

  // Per-slot decisions of the tick walk on the entry just read.
  logic walk_active;
  logic walk_zero;
  logic walk_disp;
  logic walk_dec;
  logic walk_stall;
  logic walk_go;

  assign walk_active = !rd_data.suspended;
  assign walk_zero   = (rd_data.countdown == '0);
  assign walk_disp   = walk_active && walk_zero && (rd_data.handle != '0)
                       && (disp_cnt_q < CntW'(MaxResults));
  assign walk_dec    = walk_active && !walk_zero;
  assign walk_stall  = walk_disp && pend_valid_q && !res_free;
  assign walk_go     = (state_q == S_WALK) && !walk_stall;

  // Update of one slot by a non-tick command.
  slot_entry_t cmd_entry;
  logic        cmd_write;
  logic        cmd_status;

  always_comb begin
    cmd_entry  = rd_data;
    cmd_write  = 1'b0;
    cmd_status = STATUS_OK;
    case (mode_q)
      MODE_CREATE: begin
        if (handle_q == '0) begin
          cmd_status = STATUS_NO_HANDLE;
        end else if (cmd_slot_ok && (rd_data.handle == '0)) begin
          cmd_write           = 1'b1;
          cmd_entry.handle    = handle_q;
          cmd_entry.period    = period_q;
          cmd_entry.countdown = delay_q;
          cmd_entry.suspended = 1'b0;
        end
      end
      MODE_SUSPEND: begin
        cmd_write           = cmd_slot_ok;
        cmd_entry.suspended = 1'b1;
      end
      MODE_RESUME: begin
        cmd_write           = cmd_slot_ok;
        cmd_entry.suspended = 1'b0;
      end
      MODE_DELETE: begin
        cmd_write        = cmd_slot_ok;
        cmd_entry.handle = '0;
      end
      default: begin
        cmd_write = 1'b0;
      end
    endcase
  end

  // Table port selection.
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    wr_en   = 1'b0;
    wr_addr = idx_q;
    wr_data = rd_data;
    case (state_q)
      S_IDLE: begin
        if (cmd_accept) begin
          if (cmd_i.mode == MODE_TICK) begin
            rd_en   = 1'b1;
            rd_addr = '0;
          end else begin
            rd_en   = in_slot_ok;
            rd_addr = IdxW'(cmd_i.slot);
          end
        end
      end
      S_CMD: begin
        wr_en   = res_free && cmd_write;
        wr_addr = IdxW'(slot_q);
        wr_data = cmd_entry;
      end
      S_WALK: begin
        rd_en   = walk_go && (idx_q != LastIdx);
        rd_addr = idx_q + IdxW'(1);
        wr_en   = walk_go && (walk_disp || walk_dec);
        wr_addr = idx_q;
        if (walk_disp) begin
          wr_data.countdown = rd_data.period - TimeW'(1);
        end else begin
          wr_data.countdown = rd_data.countdown - TimeW'(1);
        end
      end
      default: begin
        rd_en = 1'b0;
      end
    endcase
  end

  ptts_slot_table #(
    .TASKS (TASKS)
  ) u_table (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data)
  );

  // Sequencer with the result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      mode_q         <= '0;
      slot_q         <= '0;
      period_q       <= '0;
      delay_q        <= '0;
      handle_q       <= '0;
      idx_q          <= '0;
      disp_cnt_q     <= '0;
      pend_valid_q   <= 1'b0;
      pend_slot_q    <= '0;
      pend_handle_q  <= '0;
      res_valid_q    <= 1'b0;
      res_status_q   <= 1'b0;
      res_dispatch_q <= 1'b0;
      res_slot_q     <= '0;
      res_handle_q   <= '0;
      res_last_q     <= 1'b0;
    end else begin
      if (res_valid_q && res_o.ready) begin
        res_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (cmd_accept) begin
            mode_q       <= cmd_i.mode;
            slot_q       <= cmd_i.slot;
            period_q     <= cmd_i.period;
            delay_q      <= cmd_i.first_delay;
            handle_q     <= cmd_i.task_handle;
            idx_q        <= '0;
            disp_cnt_q   <= '0;
            pend_valid_q <= 1'b0;
            if (cmd_i.mode == MODE_TICK) begin
              state_q <= S_WALK;
            end else begin
              state_q <= S_CMD;
            end
          end
        end
        S_CMD: begin
          if (res_free) begin
            res_valid_q    <= 1'b1;
            res_status_q   <= cmd_status;
            res_dispatch_q <= 1'b0;
            res_slot_q     <= '0;
            res_handle_q   <= '0;
            res_last_q     <= 1'b1;
            state_q        <= S_IDLE;
          end
        end
        S_WALK: begin
          if (walk_go) begin
            if (walk_disp) begin
              // The held dispatch is known not to be the last one.
              if (pend_valid_q) begin
                res_valid_q    <= 1'b1;
                res_status_q   <= STATUS_OK;
                res_dispatch_q <= 1'b1;
                res_slot_q     <= pend_slot_q;
                res_handle_q   <= pend_handle_q;
                res_last_q     <= 1'b0;
              end
              pend_valid_q  <= 1'b1;
              pend_slot_q   <= SlotW'(idx_q);
              pend_handle_q <= rd_data.handle;
              disp_cnt_q    <= disp_cnt_q + CntW'(1);
            end
            if (idx_q == LastIdx) begin
              state_q <= S_FLUSH;
            end else begin
              idx_q <= idx_q + IdxW'(1);
            end
          end
        end
        S_FLUSH: begin
          // Final dispatch of the tick, or the empty result.
          if (res_free) begin
            res_valid_q    <= 1'b1;
            res_status_q   <= STATUS_OK;
            res_dispatch_q <= pend_valid_q;
            res_slot_q     <= pend_valid_q ? pend_slot_q : '0;
            res_handle_q   <= pend_valid_q ? pend_handle_q : '0;
            res_last_q     <= 1'b1;
            pend_valid_q   <= 1'b0;
            state_q        <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign res_o.valid      = res_valid_q;
  assign res_o.status     = res_status_q;
  assign res_o.dispatch   = res_dispatch_q;
  assign res_o.run_slot   = res_slot_q;
  assign res_o.run_handle = res_handle_q;
  assign res_o.last       = res_last_q;

  // A dispatch always names a task that exists.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && res_o.dispatch) |-> (res_o.run_handle != '0))
    else $error("dispatch result carries an empty handle");

  // An error status only ends a single-result command.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && res_o.status) |-> (!res_o.dispatch && res_o.last))
    else $error("error status on a dispatch or non-final result");

  // A tick never dispatches more than the result limit.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    disp_cnt_q <= CntW'(MaxResults))
    else $error("dispatch count beyond the limit");

  // An accepted command always starts work before the next one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_accept |=> (state_q != S_IDLE))
    else $error("command accepted without starting work");

endmodule : periodic_task_tick_scheduler

`default_nettype wire

// ===== sv/ptts_slot_table.sv =====
// Slot table of the periodic task tick scheduler.
// One memory of slot entries with one write and one registered read port,
// plus a valid bit per slot so that a slot never written reads as zero.
// Depends on ptts_pkg for the entry type.
`default_nettype none

module ptts_slot_table import ptts_pkg::*; #(
  parameter int unsigned TASKS = TasksDefault,
  localparam int unsigned IdxW = (TASKS > 1) ? $clog2(TASKS) : 1
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              rd_en_i,
  input  wire logic [IdxW-1:0]   rd_addr_i,
  output slot_entry_t            rd_data_o,
  input  wire logic              wr_en_i,
  input  wire logic [IdxW-1:0]   wr_addr_i,
  input  wire slot_entry_t       wr_data_i
);

  slot_entry_t      mem_q [TASKS];
  logic [TASKS-1:0] written_q;
  slot_entry_t      rd_data_q;
  logic             rd_written_q;

  // Entry storage: one write per cycle, no reset.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  // Valid bits: a slot reads as its reset value until first written.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      written_q    <= '0;
      rd_written_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        written_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_written_q <= written_q[rd_addr_i];
      end
    end
  end

  assign rd_data_o = rd_written_q ? rd_data_q : '0;

endmodule : ptts_slot_table

`default_nettype wire
